@@ rtl/tird_pkg.sv @@
// Package for the tape image record deframer: result codes, length constants
// and the byte swap helper. No dependencies.
package tird_pkg;

  localparam int unsigned OCTET_W   = 8;
  localparam int unsigned KIND_W    = 4;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned LEN_W     = 17;

  localparam logic [WORD_W-1:0] RECORD_LIMIT    = 32'd100000;
  localparam logic [LEN_W-1:0]  MAX_LEN_RESET   = 17'd100000;
  localparam logic [WORD_W-1:0] END_MEDIUM_WORD = 32'hFFFF_FFFF;
  localparam logic [7:0]        MARKER_TOP      = 8'h80;

  typedef enum logic [KIND_W-1:0] {
    KIND_DATA       = 4'd0,
    KIND_TAPE_MARK  = 4'd1,
    KIND_END_MEDIUM = 4'd2,
    KIND_MARKER     = 4'd3,
    KIND_RECORD_OK  = 4'd4,
    KIND_BAD_SIZE   = 4'd5,
    KIND_TOO_BIG    = 4'd6,
    KIND_MISMATCH   = 4'd7,
    KIND_END_TAPE   = 4'd8
  } kind_t;

  typedef enum logic [3:0] {
    PH_HEADER  = 4'b0001,
    PH_DATA    = 4'b0010,
    PH_TRAILER = 4'b0100,
    PH_PAD     = 4'b1000
  } phase_t;

  function automatic logic [WORD_W-1:0] byte_swap(input logic [WORD_W-1:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

endpackage

@@ rtl/tird_if.sv @@
// Channel interfaces for the tape image record deframer: byte input,
// result output and the configuration write channel. Depends on tird_pkg.
interface tird_in_if import tird_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OCTET_W-1:0] octet;
  logic               stream_end;
  modport source (output valid, octet, stream_end, input ready);
  modport sink   (input valid, octet, stream_end, output ready);
endinterface

interface tird_out_if import tird_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  kind;
  logic [OCTET_W-1:0] data_byte;
  logic [WORD_W-1:0]  length_word;
  modport source (output valid, kind, data_byte, length_word, input ready);
  modport sink   (input valid, kind, data_byte, length_word, output ready);
endinterface

interface tird_cfg_if import tird_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/tape_image_record_deframer.sv @@
// Tape image record deframer top level: header, data and trailer parsing
// with a one-deep result register. Depends on tird_pkg and tird_if.
//
//   channel   modport  payload
//   octets    sink     octet[7:0], stream_end
//   results   source   kind[3:0], data_byte[7:0], length_word[31:0]
//   cfg       sink     data[16:0] -> max_record_length
//
// One byte per cycle while octets.ready is high; each transaction updates the parse
// state in the cycle it is accepted, and any result enters the output register at the same clock edge.
// octets.ready is low only while a result waits in the register and
// results.ready is low. cfg is always ready.
// Synchronous reset clears the phase, byte index and length counters, the endian
// flag, the halt flag and the result valid flag, and restores max_record_length.
module tape_image_record_deframer
  import tird_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  tird_in_if.sink    octets,
  tird_out_if.source results,
  tird_cfg_if.sink   cfg
);

  logic [LEN_W-1:0]  max_record_length;
  phase_t            phase, phase_next;
  logic [1:0]        byte_index, byte_index_next;
  logic [WORD_W-1:0] header_word, header_word_next;
  logic [WORD_W-1:0] trailer_window, trailer_window_next;
  logic [LEN_W-1:0]  record_length, record_length_next;
  logic [LEN_W-1:0]  bytes_left, bytes_left_next;
  logic              swapped_order, swapped_order_next;
  logic              halted, halted_next;

  logic              accept;
  logic              emit;
  kind_t             emit_kind;
  logic [OCTET_W-1:0] emit_data;
  logic [WORD_W-1:0] emit_word;

  logic [WORD_W-1:0] hdr_full, hdr_ord, hdr_len;
  logic [WORD_W-1:0] trl_full, trl_ord, pad_full, pad_ord, rec_word;
  logic [LEN_W-1:0]  bytes_dec;

  assign octets.ready = !results.valid || results.ready;
  assign accept       = octets.valid && octets.ready;
  assign cfg.ready    = 1'b1;

  always_comb begin
    hdr_full  = {octets.octet, header_word[23:0]};
    hdr_ord   = swapped_order ? byte_swap(hdr_full) : hdr_full;
    hdr_len   = (hdr_ord > RECORD_LIMIT) ? byte_swap(hdr_ord) : hdr_ord;
    trl_full  = {octets.octet, trailer_window[23:0]};
    trl_ord   = swapped_order ? byte_swap(trl_full) : trl_full;
    pad_full  = {octets.octet, trailer_window[31:8]};
    pad_ord   = swapped_order ? byte_swap(pad_full) : pad_full;
    rec_word  = {{(WORD_W-LEN_W){1'b0}}, record_length};
    bytes_dec = (bytes_left == '0) ? '0 : bytes_left - 1'b1;
  end

  always_comb begin
    phase_next          = phase;
    byte_index_next     = byte_index;
    header_word_next    = header_word;
    trailer_window_next = trailer_window;
    record_length_next  = record_length;
    bytes_left_next     = bytes_left;
    swapped_order_next  = swapped_order;
    halted_next         = halted;
    emit                = 1'b0;
    emit_kind           = KIND_DATA;
    emit_data           = '0;
    emit_word           = '0;

    if (accept && !halted) begin
      if (octets.stream_end) begin
        phase_next      = PH_HEADER;
        byte_index_next = '0;
        emit            = 1'b1;
        emit_kind       = KIND_END_TAPE;
      end else begin
        case (phase)
          PH_HEADER: begin
            case (byte_index)
              2'd0:    header_word_next[7:0]   = octets.octet;
              2'd1:    header_word_next[15:8]  = octets.octet;
              2'd2:    header_word_next[23:16] = octets.octet;
              default: header_word_next[31:24] = octets.octet;
            endcase
            byte_index_next = byte_index + 1'b1;
            if (byte_index == 2'd3) begin
              emit      = 1'b1;
              emit_word = hdr_ord;
              if (hdr_ord == '0) begin
                emit_kind = KIND_TAPE_MARK;
              end else if (hdr_ord == END_MEDIUM_WORD) begin
                emit_kind = KIND_END_MEDIUM;
              end else if (hdr_ord[31:24] == MARKER_TOP) begin
                emit_kind = KIND_MARKER;
              end else begin
                // oversize lengths flip the sticky byte order
                if (hdr_ord > RECORD_LIMIT) swapped_order_next = !swapped_order;
                emit_word = hdr_len;
                if (hdr_len[31]) begin
                  emit_kind = KIND_MARKER;
                end else if (hdr_len > RECORD_LIMIT) begin
                  emit_kind   = KIND_BAD_SIZE;
                  halted_next = 1'b1;
                end else if (hdr_len > {{(WORD_W-LEN_W){1'b0}}, max_record_length}) begin
                  emit_kind   = KIND_TOO_BIG;
                  halted_next = 1'b1;
                end else begin
                  emit               = 1'b0;
                  record_length_next = hdr_len[LEN_W-1:0];
                  bytes_left_next    = hdr_len[LEN_W-1:0];
                  phase_next         = PH_DATA;
                end
              end
            end
          end
          PH_DATA: begin
            bytes_left_next = bytes_dec;
            if (bytes_dec == '0) begin
              phase_next      = PH_TRAILER;
              byte_index_next = '0;
            end
            emit      = 1'b1;
            emit_kind = KIND_DATA;
            emit_data = octets.octet;
          end
          PH_TRAILER: begin
            case (byte_index)
              2'd0:    trailer_window_next[7:0]   = octets.octet;
              2'd1:    trailer_window_next[15:8]  = octets.octet;
              2'd2:    trailer_window_next[23:16] = octets.octet;
              default: trailer_window_next[31:24] = octets.octet;
            endcase
            byte_index_next = byte_index + 1'b1;
            if (byte_index == 2'd3) begin
              emit_word = rec_word;
              if (trl_ord == rec_word) begin
                emit       = 1'b1;
                emit_kind  = KIND_RECORD_OK;
                phase_next = PH_HEADER;
              end else if (record_length[0]) begin
                // odd length: the first trailer byte may have been pad
                phase_next = PH_PAD;
              end else begin
                emit        = 1'b1;
                emit_kind   = KIND_MISMATCH;
                halted_next = 1'b1;
              end
            end
          end
          PH_PAD: begin
            emit       = 1'b1;
            emit_word  = rec_word;
            byte_index_next = '0;
            if (pad_ord == rec_word) begin
              emit_kind  = KIND_RECORD_OK;
              phase_next = PH_HEADER;
            end else begin
              emit_kind   = KIND_MISMATCH;
              halted_next = 1'b1;
            end
          end
          default: begin
            phase_next      = PH_HEADER;
            byte_index_next = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      byte_index        <= '0;
      record_length     <= '0;
      bytes_left        <= '0;
      swapped_order     <= 1'b0;
      halted            <= 1'b0;
      max_record_length <= MAX_LEN_RESET;
      results.valid     <= 1'b0;
    end else begin
      phase         <= phase_next;
      byte_index    <= byte_index_next;
      record_length <= record_length_next;
      bytes_left    <= bytes_left_next;
      swapped_order <= swapped_order_next;
      halted        <= halted_next;
      if (cfg.valid && cfg.ready) max_record_length <= cfg.data;
      if (octets.ready) results.valid <= accept && emit;
    end
  end

  always_ff @(posedge clk) begin
    header_word    <= header_word_next;
    trailer_window <= trailer_window_next;
    if (accept && emit) begin
      results.kind        <= emit_kind;
      results.data_byte   <= emit_data;
      results.length_word <= emit_word;
    end
  end

`ifndef SYNTHESIS
  // once halted, only reset clears it
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst) halted |=> halted)
    else $error("halt flag dropped without reset");

  // a fatal result is always paired with the halt flag
  a_fatal_halts: assert property (@(posedge clk) disable iff (rst)
    (results.valid && (results.kind == KIND_BAD_SIZE || results.kind == KIND_TOO_BIG ||
     results.kind == KIND_MISMATCH)) |-> halted)
    else $error("fatal result without halt");

  // a transaction taken while halted produces nothing
  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && halted) |=> !results.valid)
    else $error("result produced while halted");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_DATA) |-> (bytes_left <= record_length))
    else $error("data byte count exceeds record length");
`endif

endmodule

@@ test/tird_record_checker.sv @@
// Checker for the tape image record deframer: watches the octet, result and
// config channels, predicts each result and compares it field by field.
// Depends on tird_pkg and the channel interfaces in tird_if.
module tird_record_checker
  import tird_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  tird_in_if         octets,
  tird_out_if        results,
  tird_cfg_if        cfg,
  output int         fail_count,
  output int         pending,
  output int         results_seen,
  output logic [8:0] kinds_seen
);

  typedef struct packed {
    kind_t              kind;
    logic [OCTET_W-1:0] data_byte;
    logic [WORD_W-1:0]  length_word;
  } tape_result_t;

  tape_result_t awaited[$];

  // predicted parse state
  phase_t           parse_phase;
  logic [2:0]       idx;
  logic [31:0]      hdr;
  logic [LEN_W-1:0] rec_len;
  logic [LEN_W-1:0] remaining;
  logic [39:0]      window;
  logic             swapped;
  logic             halted;
  logic [LEN_W-1:0] max_len;

  int         mismatches = 0;
  int         waiting    = 0;
  int         seen       = 0;
  logic [8:0] seen_kinds = '0;

  assign fail_count   = mismatches;
  assign pending      = waiting;
  assign results_seen = seen;
  assign kinds_seen   = seen_kinds;

  function automatic logic [31:0] swap_bytes(input logic [31:0] w);
    return {w[7:0], w[15:8], w[23:16], w[31:24]};
  endfunction

  function automatic logic [31:0] in_order(input logic [31:0] raw);
    return swapped ? swap_bytes(raw) : raw;
  endfunction

  function automatic void rewind();
    parse_phase = PH_HEADER;
    idx         = '0;
    hdr         = '0;
    window      = '0;
  endfunction

  function automatic void clear_state();
    rewind();
    rec_len   = '0;
    remaining = '0;
    swapped   = 1'b0;
    halted    = 1'b0;
    max_len   = MAX_LEN_RESET;
  endfunction

  function automatic tape_result_t make_result(input kind_t k, input logic [7:0] d,
                                               input logic [31:0] w);
    tape_result_t t;
    t.kind        = k;
    t.data_byte   = d;
    t.length_word = w;
    return t;
  endfunction

  function automatic bit predict_octet(input logic [7:0] b, input logic se,
                                       output tape_result_t r);
    logic [31:0] len;
    r = make_result(KIND_DATA, 8'h00, 32'h0);
    if (halted) return 1'b0;
    if (se) begin
      rewind();
      r = make_result(KIND_END_TAPE, 8'h00, 32'h0);
      return 1'b1;
    end
    case (parse_phase)
      PH_HEADER: begin
        hdr = hdr | (32'(b) << (8 * idx[1:0]));
        idx = idx + 3'd1;
        if (idx < 3'd4) return 1'b0;
        len = in_order(hdr);
        rewind();
        if (len == 32'h0) begin
          r = make_result(KIND_TAPE_MARK, 8'h00, 32'h0);
          return 1'b1;
        end
        if (len == END_MEDIUM_WORD) begin
          r = make_result(KIND_END_MEDIUM, 8'h00, len);
          return 1'b1;
        end
        if (len[31:24] == MARKER_TOP) begin
          r = make_result(KIND_MARKER, 8'h00, len);
          return 1'b1;
        end
        // oversized length: try the other byte order, flag is sticky
        if (len > RECORD_LIMIT) begin
          len     = swap_bytes(len);
          swapped = ~swapped;
        end
        if (len[31]) begin
          r = make_result(KIND_MARKER, 8'h00, len);
          return 1'b1;
        end
        if (len > RECORD_LIMIT) begin
          halted = 1'b1;
          r = make_result(KIND_BAD_SIZE, 8'h00, len);
          return 1'b1;
        end
        if (len > 32'(max_len)) begin
          halted = 1'b1;
          r = make_result(KIND_TOO_BIG, 8'h00, len);
          return 1'b1;
        end
        rec_len     = len[LEN_W-1:0];
        remaining   = len[LEN_W-1:0];
        parse_phase = PH_DATA;
        return 1'b0;
      end
      PH_DATA: begin
        if (remaining != '0) remaining = remaining - 1'b1;
        if (remaining == '0) begin
          parse_phase = PH_TRAILER;
          idx         = '0;
          window      = '0;
        end
        r = make_result(KIND_DATA, b, 32'h0);
        return 1'b1;
      end
      PH_TRAILER: begin
        window = window | (40'(b) << (8 * idx[1:0]));
        idx    = idx + 3'd1;
        if (idx < 3'd4) return 1'b0;
        len = in_order(window[31:0]);
        if (len == 32'(rec_len)) begin
          rewind();
          r = make_result(KIND_RECORD_OK, 8'h00, 32'(rec_len));
          return 1'b1;
        end
        // odd length may carry one pad byte ahead of the trailer
        if (rec_len[0]) begin
          parse_phase = PH_PAD;
          return 1'b0;
        end
        halted = 1'b1;
        r = make_result(KIND_MISMATCH, 8'h00, 32'(rec_len));
        return 1'b1;
      end
      default: begin
        window[39:32] = b;
        len = in_order(window[39:8]);
        if (len == 32'(rec_len)) begin
          rewind();
          r = make_result(KIND_RECORD_OK, 8'h00, 32'(rec_len));
          return 1'b1;
        end
        halted = 1'b1;
        r = make_result(KIND_MISMATCH, 8'h00, 32'(rec_len));
        return 1'b1;
      end
    endcase
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp,
                                      input logic [31:0] got);
    if (got !== exp) begin
      mismatches++;
      if (mismatches <= 100)
        $error("%s: expected 0x%0h, got 0x%0h", name, exp, got);
    end
  endfunction

  always @(posedge clk) begin
    tape_result_t want;
    tape_result_t made;
    bit           produced;
    if (rst) begin
      clear_state();
      awaited.delete();
    end else begin
      // a result never comes from the octet accepted in the same cycle
      if (results.valid && results.ready) begin
        seen++;
        if (results.kind <= KIND_END_TAPE) seen_kinds[results.kind] = 1'b1;
        if (awaited.size() == 0) begin
          mismatches++;
          if (mismatches <= 100)
            $error("unexpected result transaction: kind %0d data 0x%0h length 0x%0h",
                   results.kind, results.data_byte, results.length_word);
        end else begin
          want = awaited.pop_front();
          check_field("kind", 32'(want.kind), 32'(results.kind));
          check_field("data_byte", 32'(want.data_byte), 32'(results.data_byte));
          check_field("length_word", want.length_word, results.length_word);
        end
      end
      if (octets.valid && octets.ready) begin
        produced = predict_octet(octets.octet, octets.stream_end, made);
        if (produced) awaited.push_back(made);
      end
      if (cfg.valid && cfg.ready) max_len = cfg.data;
    end
    waiting = awaited.size();
  end

endmodule

@@ test/tape_image_record_deframer_tb.sv @@
// Testbench top for the tape image record deframer: builds tape image frames,
// drives the octet and config channels and results.ready, and gives the verdict.
// Depends on tird_pkg, tird_if, the deframer RTL and tird_record_checker.
module tape_image_record_deframer_tb;
  import tird_pkg::*;

  localparam int SEG_COUNT  = 6;
  localparam int SEG_OCTETS = 140;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  tird_in_if  octets ();
  tird_out_if results ();
  tird_cfg_if cfg ();

  tape_image_record_deframer dut (
    .clk     (clk),
    .rst     (rst),
    .octets  (octets),
    .results (results),
    .cfg     (cfg)
  );

  int         chk_fails;
  int         pending;
  int         results_seen;
  logic [8:0] kinds_seen;

  tird_record_checker chk (
    .clk          (clk),
    .rst          (rst),
    .octets       (octets),
    .results      (results),
    .cfg          (cfg),
    .fail_count   (chk_fails),
    .pending      (pending),
    .results_seen (results_seen),
    .kinds_seen   (kinds_seen)
  );

  int               send_idle   = 0;
  int               recv_idle   = 0;
  int               octets_sent = 0;
  int               cfg_writes  = 0;
  bit               tape_swapped = 1'b0;
  logic [LEN_W-1:0] max_len_now = MAX_LEN_RESET;
  bit [7:0]         frame_bytes[$];

  initial begin
    results.ready = 1'b0;
    forever begin
      @(negedge clk);
      results.ready <= ($urandom_range(0, 99) >= recv_idle);
    end
  end

  initial begin
    #(12 * 600000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic put_octet(input logic [7:0] b, input logic se);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle) begin
      octets.valid <= 1'b0;
      @(negedge clk);
    end
    octets.valid      <= 1'b1;
    octets.octet      <= b;
    octets.stream_end <= se;
    do @(posedge clk); while (!octets.ready);
    octets_sent++;
  endtask

  task automatic park_octets();
    @(negedge clk);
    octets.valid <= 1'b0;
  endtask

  // block holds no work once nothing is awaited; settle waits for that, then pads by extra
  task automatic settle(input int extra);
    park_octets();
    for (int n = 0; n < 20000 && pending != 0; n++) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_max(input logic [LEN_W-1:0] v);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= v;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid   <= 1'b0;
    max_len_now = v;
    cfg_writes++;
  endtask

  task automatic push_word(input logic [31:0] w, input bit msb_first);
    for (int i = 0; i < 4; i++)
      frame_bytes.push_back(msb_first ? w[31-8*i -: 8] : w[8*i +: 8]);
  endtask

  function automatic logic [7:0] data_octet();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom);
  endfunction

  function automatic logic [LEN_W-1:0] pick_length();
    int unsigned cap;
    int unsigned r;
    cap = max_len_now;
    r   = $urandom_range(0, 99);
    if (r < 70) return LEN_W'($urandom_range(1, (cap < 12) ? cap : 12));
    if (r < 90) return LEN_W'($urandom_range(1, (cap < 64) ? cap : 64));
    if (cap <= 300) return LEN_W'(cap);
    return LEN_W'($urandom_range(13, 200));
  endfunction

  // bit 31 is set after the swap; the block flips its byte order
  function automatic logic [31:0] swapped_marker_word();
    logic [7:0] top;
    top = 8'($urandom_range(1, 254));
    if (top == MARKER_TOP) top = 8'h81;
    return {top, 16'($urandom), 8'($urandom_range(8'h80, 8'hFF))};
  endfunction

  // flip: header sent in the other order so the block toggles its flag.
  // spoil: trailer bytes all >= 0x80, never equal to a legal length.
  task automatic build_record(input logic [LEN_W-1:0] len, input bit flip,
                              input bit pad, input bit spoil);
    bit order;
    order = flip ? ~tape_swapped : tape_swapped;
    push_word(32'(len), order);
    repeat (len) frame_bytes.push_back(data_octet());
    if (spoil) begin
      repeat (len[0] ? 5 : 4) frame_bytes.push_back(8'($urandom_range(8'h80, 8'hFF)));
    end else begin
      if (pad && len[0]) frame_bytes.push_back(8'($urandom));
      push_word(32'(len), order);
    end
  endtask

  // sends the frame, possibly cut short by a stream end transaction
  task automatic ship_frame(input bit toggles, input int cut_pct);
    int cut = -1;
    if ($urandom_range(0, 99) < cut_pct) cut = $urandom_range(0, frame_bytes.size() - 1);
    for (int i = 0; i < frame_bytes.size(); i++) begin
      if (i == cut) break;
      put_octet(frame_bytes[i], 1'b0);
    end
    if (cut >= 0) put_octet(8'($urandom), 1'b1);
    if (toggles && (cut < 0 || cut >= 4)) tape_swapped = ~tape_swapped;
    frame_bytes.delete();
  endtask

  task automatic random_frame();
    int unsigned      r;
    logic [LEN_W-1:0] len;
    bit               flip;
    r = $urandom_range(0, 99);
    if (r < 55 && max_len_now != '0) begin
      len  = pick_length();
      flip = ($urandom_range(0, 99) < 15) && len[7:0] != 8'h00 && len[7:0] != MARKER_TOP;
      build_record(len, flip, 1'($urandom_range(0, 1)), 1'b0);
      ship_frame(flip, 12);
    end else if (r < 70) begin
      push_word(32'h0, tape_swapped);
      ship_frame(1'b0, 8);
    end else if (r < 77) begin
      push_word(END_MEDIUM_WORD, tape_swapped);
      ship_frame(1'b0, 8);
    end else if (r < 86) begin
      push_word({MARKER_TOP, 24'($urandom)}, tape_swapped);
      ship_frame(1'b0, 8);
    end else if (r < 94) begin
      push_word(swapped_marker_word(), tape_swapped);
      ship_frame(1'b1, 8);
    end else begin
      put_octet(8'($urandom), 1'b1);
    end
  endtask

  initial begin
    int               seg_start;
    int unsigned      pick;
    logic [LEN_W-1:0] m;
    octets.valid      = 1'b0;
    octets.octet      = '0;
    octets.stream_end = 1'b0;
    cfg.valid         = 1'b0;
    cfg.data          = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: tape mark, end of medium, both marker forms, stream end,
    // then an odd record in swapped order with a pad byte
    push_word(32'h0000_0000, 1'b0);
    ship_frame(1'b0, 0);
    push_word(END_MEDIUM_WORD, 1'b0);
    ship_frame(1'b0, 0);
    push_word(32'h80FF_FF00, 1'b0);
    ship_frame(1'b0, 0);
    push_word(32'h7F00_00FF, 1'b0);
    ship_frame(1'b1, 0);
    put_octet(8'hFF, 1'b1);
    build_record(LEN_W'(1), 1'b0, 1'b1, 1'b0);
    ship_frame(1'b0, 0);

    for (int seg = 0; seg < SEG_COUNT; seg++) begin
      settle(4);
      case (seg)
        0:       write_max(MAX_LEN_RESET);
        1:       write_max('0);
        2:       write_max(LEN_W'(17'h0FFFF));
        3:       write_max(LEN_W'($urandom_range(1, 40)));
        4:       write_max(LEN_W'($urandom_range(0, 100000)));
        default: write_max(MAX_LEN_RESET);
      endcase
      case (seg / 2)
        0: begin
          send_idle = 10;
          recv_idle = 81;
        end
        1: begin
          send_idle = 81;
          recv_idle = 10;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      seg_start = octets_sent;
      while (octets_sent - seg_start < SEG_OCTETS) random_frame();
    end

    // one halting error to close the run, then octets that must be ignored
    settle(4);
    pick = $urandom_range(0, 2);
    if (pick == 0) begin
      write_max(MAX_LEN_RESET);
      push_word({8'($urandom_range(1, 8'h7F)), 16'($urandom), 8'($urandom_range(1, 8'h7F))},
                tape_swapped);
    end else if (pick == 1) begin
      m = LEN_W'($urandom_range(0, 1000));
      write_max(m);
      push_word(32'($urandom_range(m + 1, 100000)), tape_swapped);
    end else begin
      write_max(MAX_LEN_RESET);
      build_record(LEN_W'($urandom_range(1, 12)), 1'b0, 1'b0, 1'b1);
    end
    ship_frame(1'b0, 0);
    repeat (6) put_octet(8'($urandom), $urandom_range(0, 2) == 0);

    settle(5);
    if (pending != 0) $error("%0d expected results never arrived", pending);
    $display("Sent %0d octet transactions and %0d config writes; checked %0d results",
             octets_sent, cfg_writes, results_seen);
    $display("Result kinds observed (bit per kind, end of tape high): %b", kinds_seen);
    if (chk_fails == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/tird_pkg.sv
rtl/tird_if.sv
rtl/tape_image_record_deframer.sv
test/tird_record_checker.sv
test/tape_image_record_deframer_tb.sv
